/* sv/svgpts_pkg.sv */
// ---------------------------------------------------------------------------
// svgpts_pkg: shared types and constants for the path token sequencer
// Kind codes, argument counts, letter decode and the result record.
// ---------------------------------------------------------------------------
package svgpts_pkg;

	localparam int ValueW = 32;

	typedef logic [3:0] kind_t;
	typedef logic [2:0] slot_t;

	localparam kind_t KIND_M    = 4'd0;
	localparam kind_t KIND_L    = 4'd1;
	localparam kind_t KIND_H    = 4'd2;
	localparam kind_t KIND_V    = 4'd3;
	localparam kind_t KIND_C    = 4'd4;
	localparam kind_t KIND_S    = 4'd5;
	localparam kind_t KIND_Q    = 4'd6;
	localparam kind_t KIND_T    = 4'd7;
	localparam kind_t KIND_A    = 4'd8;
	localparam kind_t KIND_Z    = 4'd9;
	localparam kind_t KIND_NONE = 4'd15;

	// arc flag slots
	localparam slot_t SLOT_LARGE_ARC = 3'd3;
	localparam slot_t SLOT_SWEEP     = 3'd4;

	// 0.5 in Q16.16
	localparam logic [ValueW-1:0] HALF_Q16 = 32'h0000_8000;

	typedef struct packed {
		logic  known;
		kind_t kind;
		logic  rel;
	} letter_dec_t;

	typedef struct packed {
		kind_t             kind;
		logic              rel;
		slot_t             slot;
		logic [ValueW-1:0] arg;
		logic              done;
		logic              err;
	} result_t;

	function automatic letter_dec_t decode_letter(input logic [7:0] ch);
		letter_dec_t d;
		d = '{known: 1'b1, kind: KIND_NONE, rel: 1'b0};
		case (ch)
			"M": d.kind = KIND_M;
			"L": d.kind = KIND_L;
			"H": d.kind = KIND_H;
			"V": d.kind = KIND_V;
			"C": d.kind = KIND_C;
			"S": d.kind = KIND_S;
			"Q": d.kind = KIND_Q;
			"T": d.kind = KIND_T;
			"A": d.kind = KIND_A;
			"Z": d.kind = KIND_Z;
			"m": begin d.kind = KIND_M; d.rel = 1'b1; end
			"l": begin d.kind = KIND_L; d.rel = 1'b1; end
			"h": begin d.kind = KIND_H; d.rel = 1'b1; end
			"v": begin d.kind = KIND_V; d.rel = 1'b1; end
			"c": begin d.kind = KIND_C; d.rel = 1'b1; end
			"s": begin d.kind = KIND_S; d.rel = 1'b1; end
			"q": begin d.kind = KIND_Q; d.rel = 1'b1; end
			"t": begin d.kind = KIND_T; d.rel = 1'b1; end
			"a": begin d.kind = KIND_A; d.rel = 1'b1; end
			"z": begin d.kind = KIND_Z; d.rel = 1'b1; end
			default: d.known = 1'b0;
		endcase
		return d;
	endfunction

	// arguments per segment kind
	function automatic logic [2:0] arg_count(input kind_t k);
		logic [2:0] n;
		case (k)
			KIND_M, KIND_L, KIND_T: n = 3'd2;
			KIND_H, KIND_V:         n = 3'd1;
			KIND_C:                 n = 3'd6;
			KIND_S, KIND_Q:         n = 3'd4;
			KIND_A:                 n = 3'd7;
			default:                n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

/* sv/svg_path_token_sequencer.sv */
// ---------------------------------------------------------------------------
// svg_path_token_sequencer: SVG path-data token sequencer
// Turns command letters and Q16.16 numbers into labeled segment arguments.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one token per transfer: a
//   command letter (token_is_number = 0) or a number (token_is_number = 1).
//   Output channel (out_valid/out_ready) carries at most one result per
//   token: an argument labeled with segment kind, mode and slot, a closepath,
//   or an error. A plain command letter other than Z gives no result.
//   A result is registered before it reaches the output. Throughput: one
//   token per cycle while in_ready is high, set by the single state
//   update and result register stage.
//   A two-entry output stage (result register plus skid register) lets the
//   block take a token while a result waits; in_ready drops only when both
//   entries hold results, and rises again as soon as the receiver takes one.
//   in_ready is a registered signal with no path from out_ready.
//   Reset: arst_n clears the sequencer state (no active or previous command)
//   and empties the output stage; no cleanup pass is needed.
// ---------------------------------------------------------------------------
module svg_path_token_sequencer import svgpts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              token_is_number,
	input  logic [7:0]        letter,
	input  logic signed [31:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        segment_kind,
	output logic              relative,
	output logic [2:0]        slot,
	output logic signed [31:0] arg_value,
	output logic              segment_done,
	output logic              error
);

	// sequencer state
	kind_t active_kind_q;
	logic  active_rel_q;
	slot_t arg_index_q;
	kind_t prev_kind_q;
	logic  prev_rel_q;

	// output stage
	result_t out_q, skid_q;
	logic    out_v_q, skid_v_q;

	// next-state / result
	kind_t       active_kind_d;
	logic        active_rel_d;
	slot_t       arg_index_d;
	kind_t       prev_kind_d;
	logic        prev_rel_d;
	result_t     res;
	logic        has_res;
	letter_dec_t dec;
	logic        act_ok, prev_ok;
	kind_t       eff_kind;
	logic        eff_rel;
	slot_t       eff_slot;
	logic [3:0]  slot_next;

	logic accept, push, pop;

	assign accept = in_valid && in_ready;
	assign push   = accept && has_res;
	assign pop    = out_v_q && out_ready;

	always_comb begin
		dec           = decode_letter(letter);
		act_ok        = (active_kind_q <= KIND_A);
		prev_ok       = (prev_kind_q <= KIND_A);
		// implicit repeat: with no active command, reuse the last one (move -> line)
		eff_kind      = act_ok ? active_kind_q : ((prev_kind_q == KIND_M) ? KIND_L : prev_kind_q);
		eff_rel       = act_ok ? active_rel_q : prev_rel_q;
		eff_slot      = act_ok ? arg_index_q : '0;
		slot_next     = {1'b0, eff_slot} + 4'd1;

		active_kind_d = active_kind_q;
		active_rel_d  = active_rel_q;
		arg_index_d   = arg_index_q;
		prev_kind_d   = prev_kind_q;
		prev_rel_d    = prev_rel_q;
		res           = '0;
		has_res       = 1'b0;

		if (!token_is_number) begin
			if (!dec.known) begin
				has_res = 1'b1;
				res.err = 1'b1;
			end else if (dec.kind == KIND_Z) begin
				// closepath completes at once and forgets any command
				has_res       = 1'b1;
				res.kind      = KIND_Z;
				res.rel       = dec.rel;
				res.done      = 1'b1;
				active_kind_d = KIND_NONE;
				active_rel_d  = 1'b0;
				arg_index_d   = '0;
				prev_kind_d   = KIND_NONE;
				prev_rel_d    = 1'b0;
			end else begin
				active_kind_d = dec.kind;
				active_rel_d  = dec.rel;
				arg_index_d   = '0;
			end
		end else if (!act_ok && !prev_ok) begin
			has_res = 1'b1;
			res.err = 1'b1;
		end else begin
			has_res  = 1'b1;
			res.kind = eff_kind;
			res.rel  = eff_rel;
			res.slot = eff_slot;
			res.arg  = value;
			if (eff_kind == KIND_A && (eff_slot == SLOT_LARGE_ARC || eff_slot == SLOT_SWEEP))
				res.arg = {31'd0, (!value[31] && (value > HALF_Q16))};
			res.done = (slot_next >= {1'b0, arg_count(eff_kind)});
			if (res.done) begin
				prev_kind_d   = eff_kind;
				prev_rel_d    = eff_rel;
				active_kind_d = KIND_NONE;
				active_rel_d  = 1'b0;
				arg_index_d   = '0;
			end else begin
				active_kind_d = eff_kind;
				active_rel_d  = eff_rel;
				arg_index_d   = slot_next[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_kind_q <= KIND_NONE;
			active_rel_q  <= 1'b0;
			arg_index_q   <= '0;
			prev_kind_q   <= KIND_NONE;
			prev_rel_q    <= 1'b0;
		end else if (accept) begin
			active_kind_q <= active_kind_d;
			active_rel_q  <= active_rel_d;
			arg_index_q   <= arg_index_d;
			prev_kind_q   <= prev_kind_d;
			prev_rel_q    <= prev_rel_d;
		end
	end

	// output valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			// input stalled; drain skid into the result register
			if (pop)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || pop)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_v_q || pop)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign in_ready     = !skid_v_q;
	assign out_valid    = out_v_q;
	assign segment_kind = out_q.kind;
	assign relative     = out_q.rel;
	assign slot         = out_q.slot;
	assign arg_value    = out_q.arg;
	assign segment_done = out_q.done;
	assign error        = out_q.err;

endmodule

/* dv/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: testbench for svg_path_token_sequencer
// Streams command letters and Q16.16 numbers into the sequencer. A directed
// table with hand-typed results comes first, then random path fragments.
// Each result is checked field by field against a cycle-free model of the
// command, slot and implicit-repeat tracking.
// ---------------------------------------------------------------------------
module tb_top;
	import svgpts_pkg::*;

	localparam int RAND_TOKENS = 1250;
	localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
	localparam int DRAIN_WAIT  = 4;     // idle cycles after the last owed result

	// per-kind command letters and argument counts, indexed by kind code
	localparam logic [7:0] CMD_CHARS [10] = '{"M", "L", "H", "V", "C", "S", "Q", "T", "A", "Z"};
	localparam int         ARG_N     [10] = '{2, 2, 1, 1, 6, 4, 4, 2, 7, 0};

	localparam result_t ERR_RES   = '{KIND_M, 1'b0, 3'd0, 32'd0, 1'b0, 1'b1};
	localparam result_t CLOSE_ABS = '{KIND_Z, 1'b0, 3'd0, 32'd0, 1'b1, 1'b0};
	localparam result_t CLOSE_REL = '{KIND_Z, 1'b1, 3'd0, 32'd0, 1'b1, 1'b0};
	localparam result_t NO_RES    = '0;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              token_is_number;
	logic [7:0]        letter;
	logic signed [31:0] value;
	logic              out_valid;
	logic              out_ready;
	logic [3:0]        segment_kind;
	logic              relative;
	logic [2:0]        slot;
	logic signed [31:0] arg_value;
	logic              segment_done;
	logic              error;

	svg_path_token_sequencer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.token_is_number(token_is_number),
		.letter         (letter),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_kind   (segment_kind),
		.relative       (relative),
		.slot           (slot),
		.arg_value      (arg_value),
		.segment_done   (segment_done),
		.error          (error)
	);

	always #4 clk = ~clk;

	// sequencer state as the model sees it (reset values)
	kind_t cur_kind  = KIND_NONE;
	logic  cur_rel   = 1'b0;
	slot_t cur_slot  = '0;
	kind_t last_kind = KIND_NONE;
	logic  last_rel  = 1'b0;

	result_t pending_args [$];  // results owed by the block, oldest first
	int      fail_count   = 0;
	int      tokens_sent  = 0;
	int      send_idle    = 34;  // percent of items preceded by an idle cycle
	int      recv_idle    = 59;  // percent of cycles with out_ready low
	int      stall_cycles = 0;

	// Directed table. Rows with typed = 1 carry a result read straight off the
	// spec (or no result when yields = 0); the rest use the model.
	typedef struct {
		bit          is_num;
		logic [7:0]  ch;
		logic [31:0] val;
		bit          typed;
		bit          yields;
		result_t     res;
	} stim_row_t;

	stim_row_t directed_rows [25] = '{
		// nothing to apply a number to right after reset
		'{1'b1, 8'h00, 32'h7FFF_FFFF, 1'b1, 1'b1, ERR_RES},
		// unknown letters at both byte extremes
		'{1'b0, 8'h00, 32'h0000_0000, 1'b1, 1'b1, ERR_RES},
		'{1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, ERR_RES},
		// closepath in both modes, no command pending
		'{1'b0, "Z",   32'h0000_0000, 1'b1, 1'b1, CLOSE_ABS},
		'{1'b0, "z",   32'h0000_0000, 1'b1, 1'b1, CLOSE_REL},
		// moveto with value extremes
		'{1'b0, "M",   32'h0000_0000, 1'b1, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h7FFF_FFFF, 1'b1, 1'b1,
			'{KIND_M, 1'b0, 3'd0, 32'h7FFF_FFFF, 1'b0, 1'b0}},
		'{1'b1, 8'h00, 32'h8000_0000, 1'b1, 1'b1,
			'{KIND_M, 1'b0, 3'd1, 32'h8000_0000, 1'b1, 1'b0}},
		// implicit repeat: moveto continues as lineto
		'{1'b1, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
		// relative arc, flags just above and exactly at one half
		'{1'b0, "a",   32'h0000_0000, 1'b1, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_8000, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_0002, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_8001, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_8000, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_0005, 1'b0, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_0006, 1'b0, 1'b0, NO_RES},
		// single-argument horizontal line
		'{1'b0, "h",   32'h0000_0000, 1'b1, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'hFFFF_0000, 1'b0, 1'b0, NO_RES},
		// unfinished quadratic dropped by closepath, then a stray number
		'{1'b0, "Q",   32'h0000_0000, 1'b1, 1'b0, NO_RES},
		'{1'b1, 8'h00, 32'h0000_0003, 1'b0, 1'b0, NO_RES},
		'{1'b0, "z",   32'h0000_0000, 1'b1, 1'b1, CLOSE_REL},
		'{1'b1, 8'h00, 32'h0000_0004, 1'b1, 1'b1, ERR_RES},
		// letter just below 'A'
		'{1'b0, "@",   32'h0000_0000, 1'b1, 1'b1, ERR_RES}
	};

	// Model of one token: returns 1 and the result when the token yields one.
	function automatic bit sequence_token(input bit is_num, input logic [7:0] ch,
			input logic [31:0] val, output result_t r);
		logic [7:0] upper;
		bit         lower_case;
		bit         found;
		kind_t      k_hit;
		int         k;
		r          = '0;
		lower_case = (ch >= "a" && ch <= "z");
		upper      = lower_case ? ch - 8'd32 : ch;
		found      = 1'b0;
		k_hit      = KIND_NONE;
		if (!is_num) begin
			for (k = 0; k < 10; k++) begin
				if (upper == CMD_CHARS[k]) begin
					found = 1'b1;
					k_hit = kind_t'(k);
				end
			end
			if (!found) begin
				r.err = 1'b1;
				return 1'b1;
			end
			cur_slot = '0;
			if (k_hit == KIND_Z) begin
				// closepath forgets both commands
				cur_kind  = KIND_NONE;
				cur_rel   = 1'b0;
				last_kind = KIND_NONE;
				last_rel  = 1'b0;
				r.kind    = KIND_Z;
				r.rel     = lower_case;
				r.done    = 1'b1;
				return 1'b1;
			end
			cur_kind = k_hit;
			cur_rel  = lower_case;
			return 1'b0;
		end
		if (cur_kind > KIND_A) begin
			if (last_kind > KIND_A) begin
				r.err = 1'b1;
				return 1'b1;
			end
			cur_kind = (last_kind == KIND_M) ? KIND_L : last_kind;
			cur_rel  = last_rel;
			cur_slot = '0;
		end
		r.kind = cur_kind;
		r.rel  = cur_rel;
		r.slot = cur_slot;
		r.arg  = val;
		if (cur_kind == KIND_A && (cur_slot == SLOT_LARGE_ARC || cur_slot == SLOT_SWEEP))
			r.arg = ($signed(val) > $signed(HALF_Q16)) ? 32'd1 : 32'd0;
		r.done = (int'(cur_slot) + 1 >= ARG_N[cur_kind]);
		if (r.done) begin
			last_kind = cur_kind;
			last_rel  = cur_rel;
			cur_kind  = KIND_NONE;
			cur_rel   = 1'b0;
			cur_slot  = '0;
		end else begin
			cur_slot = cur_slot + 3'd1;
		end
		return 1'b1;
	endfunction

	// Present one token, hold it until the transfer, then log what it owes.
	task automatic put_token(input bit is_num, input logic [7:0] ch, input logic [31:0] val,
			input bit typed, input bit yields, input result_t typed_res);
		result_t modeled;
		bit      produced;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		token_is_number <= is_num;
		letter          <= ch;
		value           <= val;
		do @(posedge clk); while (!in_ready);
		tokens_sent++;
		produced = sequence_token(is_num, ch, val, modeled);
		if (typed) begin
			if (yields)
				pending_args.push_back(typed_res);
		end else if (produced) begin
			pending_args.push_back(modeled);
		end
	endtask

	// the unused field of each token carries random bits
	task automatic put_letter(input logic [7:0] ch);
		put_token(1'b0, ch, $urandom(), 1'b0, 1'b0, NO_RES);
	endtask

	task automatic put_number(input logic [31:0] val);
		put_token(1'b1, 8'($urandom_range(255)), val, 1'b0, 1'b0, NO_RES);
	endtask

	// hold the sender off until the block owes nothing
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_args.size() != 0);
	endtask

	// numbers: full range, small signed, around one half, and corner values
	function automatic logic [31:0] draw_value();
		logic [31:0] corners [7];
		logic [31:0] v;
		corners = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, HALF_Q16, 32'hFFFF_8000};
		case ($urandom_range(3))
			0: v = $urandom();
			1: begin
				v = $urandom_range(32'h0002_0000);
				if ($urandom_range(1))
					v = -v;
			end
			2: v = HALF_Q16 + $urandom_range(4) - 32'd2;
			default: v = corners[$urandom_range(6)];
		endcase
		return v;
	endfunction

	// One random fragment: mostly a command followed by one to three full
	// argument sets (later sets exercise implicit repeat), sometimes cut
	// short; the rest is closepath, arbitrary letter bytes and lone numbers.
	task automatic put_fragment();
		int pick;
		int k;
		int sets;
		int n;
		pick = $urandom_range(99);
		if (pick < 70) begin
			k = $urandom_range(8);
			put_letter(CMD_CHARS[k] + ($urandom_range(1) ? 8'd32 : 8'd0));
			sets = $urandom_range(1, 3);
			for (int s = 0; s < sets; s++) begin
				n = ARG_N[k];
				if (s == sets - 1 && $urandom_range(9) == 0)
					n = $urandom_range(n - 1);
				for (int i = 0; i < n; i++)
					put_number(draw_value());
			end
		end else if (pick < 78) begin
			put_letter($urandom_range(1) ? "Z" : "z");
		end else if (pick < 90) begin
			put_letter(8'($urandom_range(255)));
		end else begin
			put_number(draw_value());
		end
	endtask

	// Receiver: random back-pressure, and each transfer is checked against
	// the oldest owed result. out_ready is read before its update lands.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_args.size() == 0) begin
				$error("result with nothing owed: kind %0d slot %0d err %0d",
					segment_kind, slot, error);
				fail_count++;
			end else begin
				result_t exp_res;
				exp_res = pending_args.pop_front();
				if (segment_kind !== exp_res.kind) begin
					$error("segment_kind: expected %0d, got %0d", exp_res.kind, segment_kind);
					fail_count++;
				end
				if (relative !== exp_res.rel) begin
					$error("relative: expected %0d, got %0d", exp_res.rel, relative);
					fail_count++;
				end
				if (slot !== exp_res.slot) begin
					$error("slot: expected %0d, got %0d", exp_res.slot, slot);
					fail_count++;
				end
				if (arg_value !== exp_res.arg) begin
					$error("arg_value: expected %h, got %h", exp_res.arg, arg_value);
					fail_count++;
				end
				if (segment_done !== exp_res.done) begin
					$error("segment_done: expected %0d, got %0d", exp_res.done, segment_done);
					fail_count++;
				end
				if (error !== exp_res.err) begin
					$error("error: expected %0d, got %0d", exp_res.err, error);
					fail_count++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// watchdog: give up after a long run of cycles with no transfer at all
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		token_is_number = 1'b0;
		letter          = '0;
		value           = '0;
		out_ready       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part runs under the first idling mix
		foreach (directed_rows[i])
			put_token(directed_rows[i].is_num, directed_rows[i].ch, directed_rows[i].val,
				directed_rows[i].typed, directed_rows[i].yields, directed_rows[i].res);

		// three random phases: sender-light, receiver-light, no idling
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 34 : (ph == 1) ? 59 : 0;
			recv_idle = (ph == 0) ? 59 : (ph == 1) ? 34 : 0;
			drain_results();
			while (tokens_sent < $size(directed_rows) + (ph + 1) * RAND_TOKENS / 3)
				put_fragment();
		end

		in_valid <= 1'b0;
		while (pending_args.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* svg_path_token_sequencer.f */
sv/svgpts_pkg.sv
sv/svg_path_token_sequencer.sv
dv/tb_top.sv
